FILE: hw/rtl/kcrt_pkg.sv
// ----------------------------------------------------------------------------
// kcrt_pkg
// Shared types and constants for the key combination repeat and tap detector.
// ----------------------------------------------------------------------------
`default_nettype none

package kcrt_pkg;

    // Sizing
    localparam int SLOTS     = 256;
    localparam int MAX_COMBO = 4;
    localparam int TIME_BITS = 24;

    localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    // Serial divider: two quotient bits per cycle
    localparam int DIV_STEPS = (TIME_BITS + 1) / 2;
    localparam int QUO_W     = 2 * DIV_STEPS;
    localparam int DCNT_W    = $clog2(DIV_STEPS + 1);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_DELAY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_PERIOD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_LIMIT     = 2'd2;

    // Event kinds
    localparam logic [1:0] KIND_PRESS   = 2'd0;
    localparam logic [1:0] KIND_REPEAT  = 2'd1;
    localparam logic [1:0] KIND_RELEASE = 2'd2;
    localparam logic [1:0] KIND_TAP     = 2'd3;

    typedef struct packed {
        logic [7:0]  slot;
        logic [2:0]  combo_len;
        logic [3:0]  keys_down;
        logic [15:0] elapsed;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] event_slot;
        logic [1:0] event_kind;
        logic       last;
    } t_out_beat;

    typedef struct packed {
        logic                 held;
        logic [TIME_BITS-1:0] hold;
    } t_entry;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        t_entry            data;
    } t_mem_wr;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV,
        ST_EMIT
    } t_state;

endpackage

`default_nettype wire

FILE: hw/rtl/kcrt_mem.sv
// ----------------------------------------------------------------------------
// kcrt_mem
// Slot state table: one write port, one registered read port. Entries never
// written since reset read as zero through per-entry valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module kcrt_mem
    import kcrt_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_rd_en,
    input  wire logic [SLOT_W-1:0] i_rd_addr,
    output      t_entry            o_rd_data,
    input  wire t_mem_wr           i_wr
);

    t_entry             r_mem [SLOTS];
    logic [SLOTS-1:0]   r_vld;
    t_entry             r_rd_data;
    logic               r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_vld[i_wr.addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    // Unwritten entry reads as reset value
    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

`default_nettype wire

FILE: hw/rtl/kcrt_div.sv
// ----------------------------------------------------------------------------
// kcrt_div
// Unsigned restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module kcrt_div
    import kcrt_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [TIME_BITS-1:0] i_dividend,
    input  wire logic [CFG_W-1:0]     i_divisor,
    output      logic                 o_busy,
    output      logic [QUO_W-1:0]     o_quo
);

    logic [DCNT_W-1:0] r_cnt;
    logic [QUO_W-1:0]  r_quo;
    logic [CFG_W-1:0]  r_rem;
    logic [CFG_W-1:0]  r_div;

    logic [QUO_W-1:0]  n_quo;
    logic [CFG_W-1:0]  n_rem;
    logic [CFG_W:0]    trial;
    logic              qbit;

    // Two dependent shift-subtract steps
    always_comb begin
        n_quo = r_quo;
        n_rem = r_rem;
        for (int k = 0; k < 2; k++) begin
            trial = {n_rem, n_quo[QUO_W-1]};
            qbit  = (trial >= {1'b0, r_div});
            if (qbit) begin
                trial = trial - {1'b0, r_div};
            end
            n_rem = trial[CFG_W-1:0];
            n_quo = {n_quo[QUO_W-2:0], qbit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= DCNT_W'(DIV_STEPS);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= QUO_W'(i_dividend);
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_cnt != '0) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

FILE: hw/rtl/key_combo_repeat_tap_detector_top.sv
// ----------------------------------------------------------------------------
// key_combo_repeat_tap_detector_top
// Per-slot key combination press, typematic repeat, release and tap events.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall, payload i_in) carries one binding
//   evaluation per beat: slot, combination length, key mask, elapsed ticks.
//   Output channel (o_out_valid / i_out_stall, payload o_out) carries zero,
//   one or two event beats per input beat; the final one has last set.
//   Configuration writes (i_cfg_we / i_cfg_idx / i_cfg_data) set repeat
//   delay, repeat period and tap limit; write them only while idle.
// Timing:
//   One input beat at a time. A beat passes through ST_READ and then ST_EMIT
//   when the slot is not held or is released, and through ST_READ, ST_DIV and
//   ST_EMIT for a held slot, where two serial dividers (two quotient bits a
//   cycle) compute the whole-period counts before and after adding the elapsed
//   ticks. Events are loaded into the output register in ST_EMIT. The slot
//   table is a synchronous RAM read once and written at most once per beat.
// Reset:
//   Synchronous, active low. Registers return to 500 / 50 / 200 and every
//   slot reads as not pressed with a zero count (valid bits, no sweep).
// Backpressure:
//   Events wait in a two-entry output register; the next input beat is
//   taken while they drain, and the following one waits until they leave.
// ----------------------------------------------------------------------------
`default_nettype none

module key_combo_repeat_tap_detector_top
    import kcrt_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output      logic                 o_in_stall,
    input  wire t_in_beat             i_in,
    output      logic                 o_out_valid,
    input  wire logic                 i_out_stall,
    output      t_out_beat            o_out,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] r_delay;
    logic [CFG_W-1:0] r_period;
    logic [CFG_W-1:0] r_tap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay  <= CFG_W'(500);
            r_period <= CFG_W'(50);
            r_tap    <= CFG_W'(200);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_REPEAT_DELAY:  r_delay  <= i_cfg_data;
                CFG_REPEAT_PERIOD: r_period <= i_cfg_data;
                CFG_TAP_LIMIT:     r_tap    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input decode
    // ------------------------------------------------------------------
    t_state r_state;
    t_state n_state;

    logic       in_acc;
    logic       in_range;
    logic [2:0] len_c;
    logic [4:0] need_w;
    logic [3:0] need;
    logic       sat_in;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign in_range = ({24'd0, i_in.slot} < 32'(SLOTS));
    assign len_c    = (i_in.combo_len > 3'(MAX_COMBO)) ? 3'(MAX_COMBO) : i_in.combo_len;
    assign need_w   = (5'd1 << len_c) - 5'd1;
    assign need     = need_w[3:0];
    assign sat_in   = (len_c != 3'd0) && ((i_in.keys_down & need) == need);

    logic [7:0]  r_slot;
    logic        r_sat;
    logic [15:0] r_elapsed;

    // Hold the beat for the duration of its evaluation
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_slot    <= i_in.slot;
            r_sat     <= sat_in;
            r_elapsed <= i_in.elapsed;
        end
    end

    // ------------------------------------------------------------------
    // Slot table
    // ------------------------------------------------------------------
    t_entry  rd;
    t_mem_wr mem_wr;

    kcrt_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_acc),
        .i_rd_addr (SLOT_W'(i_in.slot)),
        .o_rd_data (rd),
        .i_wr      (mem_wr)
    );

    // ------------------------------------------------------------------
    // Hold count update and relative times
    // ------------------------------------------------------------------
    logic [TIME_BITS:0]          sum;
    logic [TIME_BITS-1:0]        cur;
    logic signed [TIME_BITS:0]   cur_rel;
    logic signed [TIME_BITS:0]   prev_rel;
    logic signed [TIME_BITS:0]   cur_neg_v;
    logic signed [TIME_BITS:0]   prev_neg_v;
    logic [TIME_BITS-1:0]        cur_mag;
    logic [TIME_BITS-1:0]        prev_mag;
    logic [CFG_W-1:0]            period_eff;
    logic                        tap_ok;

    assign sum        = {1'b0, rd.hold} + (TIME_BITS+1)'(r_elapsed);
    assign cur        = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
    assign cur_rel    = $signed({1'b0, cur}) - $signed((TIME_BITS+1)'(r_delay));
    assign prev_rel   = $signed({1'b0, rd.hold}) - $signed((TIME_BITS+1)'(r_delay));
    assign cur_neg_v  = -cur_rel;
    assign prev_neg_v = -prev_rel;
    assign cur_mag    = cur_rel[TIME_BITS]  ? cur_neg_v[TIME_BITS-1:0]
                                            : cur_rel[TIME_BITS-1:0];
    assign prev_mag   = prev_rel[TIME_BITS] ? prev_neg_v[TIME_BITS-1:0]
                                            : prev_rel[TIME_BITS-1:0];
    assign period_eff = (r_period == '0) ? CFG_W'(1) : r_period;
    assign tap_ok     = (rd.hold <= TIME_BITS'(r_tap));

    // ------------------------------------------------------------------
    // Serial dividers: whole periods past the delay, before and after
    // ------------------------------------------------------------------
    logic             div_start;
    logic             cur_busy;
    logic             prev_busy;
    logic [QUO_W-1:0] cur_quo;
    logic [QUO_W-1:0] prev_quo;

    kcrt_div u_div_cur (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (cur_mag),
        .i_divisor  (period_eff),
        .o_busy     (cur_busy),
        .o_quo      (cur_quo)
    );

    kcrt_div u_div_prev (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (prev_mag),
        .i_divisor  (period_eff),
        .o_busy     (prev_busy),
        .o_quo      (prev_quo)
    );

    logic r_cur_pos;
    logic r_cur_neg;
    logic r_prev_neg;

    // Keep signs while the dividers run on magnitudes
    always_ff @(posedge i_clk) begin
        if (div_start) begin
            r_cur_pos  <= !cur_rel[TIME_BITS] && (cur_rel != '0);
            r_cur_neg  <= cur_rel[TIME_BITS];
            r_prev_neg <= prev_rel[TIME_BITS];
        end
    end

    logic signed [QUO_W:0] q_cur;
    logic signed [QUO_W:0] q_prev;
    logic                  rep_hit;

    // Truncating division: quotient takes the dividend's sign
    assign q_cur   = r_cur_neg  ? -$signed({1'b0, cur_quo})  : $signed({1'b0, cur_quo});
    assign q_prev  = r_prev_neg ? -$signed({1'b0, prev_quo}) : $signed({1'b0, prev_quo});
    assign rep_hit = r_cur_pos && (q_cur > q_prev);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic       div_done;
    logic       out_acc;
    logic       out_load;
    logic [1:0] r_out_cnt;

    assign div_done = !cur_busy && !prev_busy;
    assign out_acc  = o_out_valid && !i_out_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && in_range) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = (rd.held && r_sat) ? ST_DIV : ST_EMIT;
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (r_out_cnt == 2'd0) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_in_stall = 1'b1;
        div_start  = 1'b0;
        out_load   = 1'b0;
        mem_wr     = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
            end
            ST_READ: begin
                mem_wr.addr = SLOT_W'(r_slot);
                if (rd.held) begin
                    // Held: advance the count, or drop it on release
                    mem_wr.en        = 1'b1;
                    mem_wr.data.held = r_sat;
                    mem_wr.data.hold = r_sat ? cur : '0;
                    div_start        = r_sat;
                end else if (r_sat) begin
                    mem_wr.en        = 1'b1;
                    mem_wr.data.held = 1'b1;
                    mem_wr.data.hold = '0;
                end
            end
            ST_DIV: ;
            ST_EMIT: begin
                out_load = (r_out_cnt == 2'd0);
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Pending events for the current beat
    // ------------------------------------------------------------------
    logic [1:0] r_pend_cnt;
    logic [1:0] r_pend_k0;
    logic [1:0] r_pend_k1;

    always_ff @(posedge i_clk) begin
        if (r_state == ST_READ) begin
            r_pend_k1 <= KIND_TAP;
            if (rd.held && !r_sat) begin
                r_pend_cnt <= tap_ok ? 2'd2 : 2'd1;
                r_pend_k0  <= KIND_RELEASE;
            end else if (!rd.held && r_sat) begin
                r_pend_cnt <= 2'd1;
                r_pend_k0  <= KIND_PRESS;
            end else begin
                r_pend_cnt <= 2'd0;
                r_pend_k0  <= KIND_REPEAT;
            end
        end else if (r_state == ST_DIV && div_done) begin
            r_pend_cnt <= rep_hit ? 2'd1 : 2'd0;
            r_pend_k0  <= KIND_REPEAT;
        end
    end

    // ------------------------------------------------------------------
    // Output register: up to two event beats
    // ------------------------------------------------------------------
    logic [1:0] r_out_k0;
    logic [1:0] r_out_k1;
    logic [7:0] r_out_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_cnt <= 2'd0;
        end else if (out_load) begin
            r_out_cnt <= r_pend_cnt;
        end else if (out_acc) begin
            r_out_cnt <= r_out_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_k0   <= r_pend_k0;
            r_out_k1   <= r_pend_k1;
            r_out_slot <= r_slot;
        end else if (out_acc) begin
            r_out_k0 <= r_out_k1;
        end
    end

    assign o_out_valid      = (r_out_cnt != 2'd0);
    assign o_out.event_slot = r_out_slot;
    assign o_out.event_kind = r_out_k0;
    assign o_out.last       = (r_out_cnt == 2'd1);

endmodule

`default_nettype wire

FILE: hw/rtl/kcrt_checker.sv
// ----------------------------------------------------------------------------
// kcrt_checker
// Port-level checks for the key combination repeat and tap detector.
// ----------------------------------------------------------------------------
`default_nettype none

module kcrt_checker
    import kcrt_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 o_out_valid,
    input wire logic                 i_out_stall,
    input wire t_out_beat            o_out
);

    // Reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // Stalled event beat holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled event beat changed");

    // Second event of a pair is ready right after the first leaves
    a_pair_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.last && !i_out_stall |=> o_out_valid)
        else $error("second event of pair missing");

    // Only release is ever followed by another event
    a_nonlast_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.last |-> o_out.event_kind == KIND_RELEASE)
        else $error("non-final event is not release");

    // Tap always closes its beat's events
    a_tap_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.event_kind == KIND_TAP |-> o_out.last)
        else $error("tap event not final");

endmodule

bind key_combo_repeat_tap_detector_top kcrt_checker u_kcrt_checker (.*);

`default_nettype wire
